@@ hdl/des_pkg.sv @@
// DES tables, stage type and bit-permutation functions shared by the cipher modules.
package des_pkg;

  localparam int unsigned Rounds = 16;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_t;

  // Data and key-schedule halves handed from one round cell to the next.
  typedef struct packed {
    op_t         op;
    logic [31:0] l;
    logic [31:0] r;
    logic [27:0] c;
    logic [27:0] d;
  } stage_t;

  localparam logic [6:0] IP_TAB [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  localparam logic [6:0] FP_TAB [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
  };

  localparam logic [5:0] E_TAB [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
    6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
    6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
    6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
    6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] P_TAB [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [6:0] PC1_TAB [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [6:0] PC2_TAB [48] = '{
    7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,
    7'd3,  7'd28, 7'd15, 7'd6,  7'd21, 7'd10,
    7'd23, 7'd19, 7'd12, 7'd4,  7'd26, 7'd8,
    7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
    7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55,
    7'd30, 7'd40, 7'd51, 7'd45, 7'd33, 7'd48,
    7'd44, 7'd49, 7'd39, 7'd56, 7'd34, 7'd53,
    7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32
  };

  // Left rotations for encryption; right rotations that walk the schedule backward.
  localparam logic [1:0] ENC_ROT [Rounds] = '{
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
  };

  localparam logic [1:0] DEC_ROT [Rounds] = '{
    2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
  };

  localparam logic [3:0] SBOX [8][64] = '{
    '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
      4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
      4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
      4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
      4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
      4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
      4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
      4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
    '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
      4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
      4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
      4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
      4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
      4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
      4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
      4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
    '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
      4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
      4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
      4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
      4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
      4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
      4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
      4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
    '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
      4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
      4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
      4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
      4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
      4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
      4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
      4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
    '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
      4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
      4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
      4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
      4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
      4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
      4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
      4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
    '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
      4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
      4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
      4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
      4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
      4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
      4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
      4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
    '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
      4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
      4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
      4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
      4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
      4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
      4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
      4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
    '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
      4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
      4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
      4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
      4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
      4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
      4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
      4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}
  };

  // Table entries number bits from 1 at the MSB; output bits fill from the MSB down.
  function automatic logic [63:0] ip_perm(logic [63:0] x);
    logic [63:0] y;
    logic [5:0]  idx;
    for (int i = 0; i < 64; i++) begin
      idx = 6'(7'd64 - IP_TAB[i]);
      y[63-i] = x[idx];
    end
    return y;
  endfunction

  function automatic logic [63:0] fp_perm(logic [63:0] x);
    logic [63:0] y;
    logic [5:0]  idx;
    for (int i = 0; i < 64; i++) begin
      idx = 6'(7'd64 - FP_TAB[i]);
      y[63-i] = x[idx];
    end
    return y;
  endfunction

  function automatic logic [47:0] e_expand(logic [31:0] x);
    logic [47:0] y;
    logic [4:0]  idx;
    for (int i = 0; i < 48; i++) begin
      idx = 5'(7'd32 - {1'b0, E_TAB[i]});
      y[47-i] = x[idx];
    end
    return y;
  endfunction

  function automatic logic [31:0] p_perm(logic [31:0] x);
    logic [31:0] y;
    logic [4:0]  idx;
    for (int i = 0; i < 32; i++) begin
      idx = 5'(7'd32 - {1'b0, P_TAB[i]});
      y[31-i] = x[idx];
    end
    return y;
  endfunction

  function automatic logic [55:0] pc1_perm(logic [63:0] x);
    logic [55:0] y;
    logic [5:0]  idx;
    for (int i = 0; i < 56; i++) begin
      idx = 6'(7'd64 - PC1_TAB[i]);
      y[55-i] = x[idx];
    end
    return y;
  endfunction

  function automatic logic [47:0] pc2_perm(logic [55:0] x);
    logic [47:0] y;
    logic [5:0]  idx;
    for (int i = 0; i < 48; i++) begin
      idx = 6'(7'd56 - PC2_TAB[i]);
      y[47-i] = x[idx];
    end
    return y;
  endfunction

  // Row comes from the outer bits of each six-bit group, column from the inner four.
  function automatic logic [31:0] sbox_sub(logic [47:0] x);
    logic [31:0] y;
    logic [5:0]  six;
    for (int i = 0; i < 8; i++) begin
      six = x[47-6*i -: 6];
      y[31-4*i -: 4] = SBOX[i][{six[5], six[0], six[4:1]}];
    end
    return y;
  endfunction

  function automatic logic [27:0] rol28(logic [27:0] v, logic [1:0] amt);
    logic [27:0] y;
    unique case (amt)
      2'd0:    y = v;
      2'd1:    y = {v[26:0], v[27]};
      2'd2:    y = {v[25:0], v[27:26]};
      default: y = {v[24:0], v[27:25]};
    endcase
    return y;
  endfunction

  function automatic logic [27:0] ror28(logic [27:0] v, logic [1:0] amt);
    logic [27:0] y;
    unique case (amt)
      2'd0:    y = v;
      2'd1:    y = {v[0], v[27:1]};
      2'd2:    y = {v[1:0], v[27:2]};
      default: y = {v[2:0], v[27:3]};
    endcase
    return y;
  endfunction

endpackage

@@ hdl/des_block_cipher_top.sv @@
// DES block cipher top level: key register, IP/PC-1 entry, sixteen round cells and FP.
//
// Usage:
//   Load the 64-bit key through cipher_key_we / cipher_key while no item is in
//   flight; parity bits are ignored. Present an item by raising start with
//   operation (0 encrypt, 1 decrypt) and data_block; it is taken at any edge
//   where start is high, since busy is always low.
//   The result appears on result_block with done high for exactly one cycle,
//   once the item has passed through one register per round cell.
//   Throughput is one item per cycle: each of the sixteen cells holds one
//   item and passes it on every cycle, along with that item's key halves.
//   Results leave in the order items came in.
//   Reset clears the key to zero and drops every item in flight.
//   The receiver cannot stall; done is a one-cycle strobe.
module des_block_cipher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cipher_key_we,
  input  logic [63:0] cipher_key,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [63:0] data_block,
  output logic        done,
  output logic [63:0] result_block
);

  localparam int unsigned Rounds = des_pkg::Rounds;

  logic [63:0]     key_value;
  logic [63:0]     ip_block;
  logic [55:0]     cd_init;
  logic [Rounds:0] vld;
  des_pkg::stage_t stage [Rounds+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_value <= 64'd0;
    end else if (cipher_key_we) begin
      key_value <= cipher_key;
    end
  end

  assign busy = 1'b0;

  assign ip_block = des_pkg::ip_perm(data_block);
  assign cd_init  = des_pkg::pc1_perm(key_value);
  assign vld[0]   = start & ~busy;
  assign stage[0] = '{
    op: des_pkg::op_t'(operation),
    l:  ip_block[63:32],
    r:  ip_block[31:0],
    c:  cd_init[55:28],
    d:  cd_init[27:0]
  };

  for (genvar g = 0; g < Rounds; g++) begin : g_round
    des_round_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (vld[g]),
      .stage_in  (stage[g]),
      .enc_shift (des_pkg::ENC_ROT[g]),
      .dec_shift (des_pkg::DEC_ROT[g]),
      .valid_out (vld[g+1]),
      .stage_out (stage[g+1])
    );
  end

  // Undo the last swap, then apply the final permutation.
  assign done         = vld[Rounds];
  assign result_block = des_pkg::fp_perm({stage[Rounds].r, stage[Rounds].l});

  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##16 done)
    else $error("accepted item did not come out after sixteen cycles");

  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 16))
    else $error("result strobe without an item accepted sixteen cycles before");

  a_busy_low: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("pipeline refused an item");

endmodule

@@ hdl/des_round_cell.sv @@
// One Feistel round cell: steps the key halves, forms the round key and registers the round.
module des_round_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid_in,
  input  des_pkg::stage_t stage_in,
  input  logic [1:0]      enc_shift,
  input  logic [1:0]      dec_shift,
  output logic            valid_out,
  output des_pkg::stage_t stage_out
);

  logic [27:0] c_rot;
  logic [27:0] d_rot;
  logic [47:0] round_key;
  logic [31:0] f_out;

  always_comb begin
    // Decrypt walks the schedule backward with right rotations.
    if (stage_in.op == des_pkg::OP_DECRYPT) begin
      c_rot = des_pkg::ror28(stage_in.c, dec_shift);
      d_rot = des_pkg::ror28(stage_in.d, dec_shift);
    end else begin
      c_rot = des_pkg::rol28(stage_in.c, enc_shift);
      d_rot = des_pkg::rol28(stage_in.d, enc_shift);
    end
    round_key = des_pkg::pc2_perm({c_rot, d_rot});
    f_out = des_pkg::p_perm(des_pkg::sbox_sub(des_pkg::e_expand(stage_in.r) ^ round_key));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    stage_out.op <= stage_in.op;
    stage_out.l  <= stage_in.r;
    stage_out.r  <= stage_in.l ^ f_out;
    stage_out.c  <= c_rot;
    stage_out.d  <= d_rot;
  end

  a_swap_halves: assert property (@(posedge clk) disable iff (rst)
    valid_out |-> stage_out.l == $past(stage_in.r))
    else $error("round cell lost the right half in the swap");

  a_op_follows: assert property (@(posedge clk) disable iff (rst)
    valid_out |-> stage_out.op == $past(stage_in.op))
    else $error("round cell changed the operation of an item");

  a_valid_from_input: assert property (@(posedge clk) disable iff (rst)
    valid_out |-> $past(valid_in))
    else $error("round cell produced an item it never took in");

endmodule
